// ===== src/aes_pkg.sv =====
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int IDX_BITS   = 1;

    typedef logic [127:0] block_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } reg_idx_t;

    typedef logic [7:0] rcon_tbl_t [NUM_ROUNDS];
    localparam rcon_tbl_t RCON = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                   8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    typedef logic [7:0] sbox_tbl_t [256];
    localparam sbox_tbl_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(block_t b, int i);
        return b[127-8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // next round key from the previous one
    function automatic block_t next_key(block_t k, logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic block_t sub_shift(block_t s);
        block_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
            end
        end
        return t;
    endfunction

    function automatic block_t mix(block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4*c);
            a1  = get_byte(s, 4*c+1);
            a2  = get_byte(s, 4*c+2);
            a3  = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127-32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                 a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
        end
        return t;
    endfunction

endpackage

// ===== src/aes_round.sv =====
// one cipher round stage: data and its round key travel together
module aes_round #(
    parameter int ROUND = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  aes_pkg::block_t in_state,
    input  aes_pkg::block_t in_key,
    output logic           out_valid,
    output aes_pkg::block_t out_state,
    output aes_pkg::block_t out_key
);

    aes_pkg::block_t key_next;
    aes_pkg::block_t state_next;
    aes_pkg::block_t ss;
    logic            valid_reg;
    aes_pkg::block_t state_reg;
    aes_pkg::block_t key_reg;

    always_comb
    begin
        key_next = aes_pkg::next_key(in_key, aes_pkg::RCON[ROUND-1]);
        ss       = aes_pkg::sub_shift(in_state);
        if (ROUND == aes_pkg::NUM_ROUNDS)
            state_next = ss ^ key_next;
        else
            state_next = aes_pkg::mix(ss) ^ key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        key_reg   <= key_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_key   = key_reg;

endmodule

// ===== src/aes128_block_encrypt.sv =====
// AES-128 encryption, fully unrolled: a block is accepted in every cycle
// (busy is always low) and its ciphertext appears with done high after
// one stage for the initial key add and then one register stage per
// round, the round key being expanded alongside the data. The
// key used is the one held in the key registers when start is taken;
// results cannot be held off, so done is a one-cycle strobe.
module aes128_block_encrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] plain_high,
    input  logic [63:0] plain_low,
    output logic        done,
    output logic [63:0] cipher_high,
    output logic [63:0] cipher_low,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int N = aes_pkg::NUM_ROUNDS;

    logic [63:0]     key_high_reg;
    logic [63:0]     key_low_reg;
    logic            v0_reg;
    aes_pkg::block_t s0_reg;
    aes_pkg::block_t k0_reg;

    logic            v  [N+1];
    aes_pkg::block_t st [N+1];
    aes_pkg::block_t kk [N+1];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            v0_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == aes_pkg::REG_KEY_HIGH)
                key_high_reg <= cfg_data;
            if (cfg_valid && cfg_index == aes_pkg::REG_KEY_LOW)
                key_low_reg <= cfg_data;
            v0_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= {plain_high, plain_low} ^ {key_high_reg, key_low_reg};
        k0_reg <= {key_high_reg, key_low_reg};
    end

    assign v[0]  = v0_reg;
    assign st[0] = s0_reg;
    assign kk[0] = k0_reg;

    for (genvar r = 1; r <= N; r++)
    begin : g_round
        aes_round #(.ROUND(r)) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[r-1]),
            .in_state  (st[r-1]),
            .in_key    (kk[r-1]),
            .out_valid (v[r]),
            .out_state (st[r]),
            .out_key   (kk[r])
        );
    end

    assign done        = v[N];
    assign cipher_high = st[N][127:64];
    assign cipher_low  = st[N][63:0];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start, N + 1) |-> done)
        else $error("missing result");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v0_reg, N))
        else $error("result without transaction");
    a_stage_valid: assert property (@(posedge clk) disable iff (!rst_n)
        v[1] == $past(v0_reg))
        else $error("valid lost in first round");

endmodule
